// File: rtl/core/lms_adaptive_fir_assert.svh
// Assertion macros for the LMS adaptive FIR core.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef LMS_ADAPTIVE_FIR_ASSERT_SVH
`define LMS_ADAPTIVE_FIR_ASSERT_SVH
`ifndef SYNTHESIS
// implication in the same cycle
`define LMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");
// implication in the next cycle
`define LMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");
`else
`define LMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/lms_pkg.sv
// Shared types and constants of the LMS adaptive FIR core.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package lms_pkg;

    localparam int TAPS_DEF = 16;

    localparam int SMP_W   = 16;                  // Q1.15 samples
    localparam int WGT_W   = 24;                  // Q4.20 weights
    localparam int STEP_W  = 16;                  // Q0.16 mu
    localparam int WP_W    = WGT_W + SMP_W;       // weight x tap product
    localparam int MUE_W   = STEP_W + SMP_W + 2;  // 2 * mu * e
    localparam int PROD_W  = MUE_W + SMP_W;       // shared multiplier output
    localparam int Y_SHIFT = 20;
    localparam int W_SHIFT = 26;

    localparam int SMP_MAX = 2 ** (SMP_W - 1) - 1;
    localparam int SMP_MIN = -(2 ** (SMP_W - 1));
    localparam int WGT_MAX = 2 ** (WGT_W - 1) - 1;
    localparam int WGT_MIN = -(2 ** (WGT_W - 1));

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

    typedef logic signed [SMP_W-1:0] sample_t;

    typedef enum logic [1:0] {
        ACT_ADAPT   = 2'd0,
        ACT_FILTER  = 2'd1,
        ACT_CLR_WIN = 2'd2,
        ACT_CLR_ALL = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_MAC_WAIT,
        ST_YE,
        ST_MUE,
        ST_UPD,
        ST_UPD_WAIT,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic take;      // item accepted this cycle
        logic issue;     // read tap/weight at the current index
        logic upd;       // pipeline in weight-update mode
        logic form_y;    // round/saturate y and e
        logic form_mue;  // register 2*mu*e
        logic load_out;  // move y/e/full to output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic will_full; // window full once this item's sample is in
        logic last;      // index at final tap
        logic drained;   // MAC pipeline empty
        logic adapt;     // current item adapts
        logic out_free;  // output register can take a result
    } status_t;

endpackage

`default_nettype wire

// File: rtl/core/lms_in_if.sv
// Input channel of the LMS adaptive FIR: valid/ready plus one item.
// Depends on lms_pkg.
`default_nettype none

interface lms_in_if;
    import lms_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    sample_t desired;
    action_t action;

    modport source (output valid, sample, desired, action, input ready);
    modport sink   (input valid, sample, desired, action, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lms_out_if.sv
// Result channel of the LMS adaptive FIR: valid/ready plus one result item.
// Depends on lms_pkg.
`default_nettype none

interface lms_out_if;
    import lms_pkg::*;

    logic    valid;
    logic    ready;
    sample_t filter_out;
    sample_t error_out;
    logic    window_full;

    modport source (output valid, filter_out, error_out, window_full, input ready);
    modport sink   (input valid, filter_out, error_out, window_full, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lms_ctrl.sv
// Sequencer of the LMS adaptive FIR: filter pass, error, weight-update pass.
// Depends on lms_pkg; drives the datapath through cmd_t, watches status_t.
`default_nettype none

module lms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  lms_pkg::action_t in_action,
    input  lms_pkg::status_t status,
    output logic             in_ready,
    output lms_pkg::cmd_t    cmd
);
    import lms_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    unique case (in_action) inside
                        ACT_CLR_WIN, ACT_CLR_ALL: state_next = ST_IDLE;
                        default:
                        begin
                            state_next = status.will_full ? ST_MAC : ST_DONE;
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                cmd.issue = 1'b1;
                if (status.last)
                begin
                    state_next = ST_MAC_WAIT;
                end
            end
            ST_MAC_WAIT:
            begin
                if (status.drained)
                begin
                    state_next = ST_YE;
                end
            end
            ST_YE:
            begin
                cmd.form_y = 1'b1;
                state_next = status.adapt ? ST_MUE : ST_DONE;
            end
            ST_MUE:
            begin
                cmd.form_mue = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.issue = 1'b1;
                cmd.upd   = 1'b1;
                if (status.last)
                begin
                    state_next = ST_UPD_WAIT;
                end
            end
            ST_UPD_WAIT:
            begin
                cmd.upd = 1'b1;
                if (status.drained)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/lms_dp.sv
// Datapath of the LMS adaptive FIR: tap and weight memories, one shared
// multiplier with accumulate / weight-update back end, output register.
// Depends on lms_pkg and lms_adaptive_fir_assert.svh.
`default_nettype none
`include "lms_adaptive_fir_assert.svh"

module lms_dp #(
    parameter int TAPS = lms_pkg::TAPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lms_pkg::STEP_W-1:0]  cfg_wr_data,
    input  lms_pkg::sample_t            in_sample,
    input  lms_pkg::sample_t            in_desired,
    input  lms_pkg::action_t            in_action,
    input  lms_pkg::cmd_t               cmd,
    output lms_pkg::status_t            status,
    input  logic                        out_ready,
    output logic                        out_valid,
    output lms_pkg::sample_t            filter_out,
    output lms_pkg::sample_t            error_out,
    output logic                        window_full
);
    import lms_pkg::*;

    localparam int IDX_W  = $clog2(TAPS);
    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int ACC_W  = WP_W + IDX_W;
    localparam int ACC1_W = ACC_W + 1;
    localparam int E_W    = SMP_W + 1;
    localparam int P1_W   = PROD_W + 1;
    localparam int WS_W   = WGT_W + 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TAPS);

    localparam logic signed [ACC1_W-1:0] Y_HALF = ACC1_W'(2 ** (Y_SHIFT - 1));
    localparam logic signed [ACC1_W-1:0] Y_MAX  = ACC1_W'(SMP_MAX);
    localparam logic signed [ACC1_W-1:0] Y_MIN  = ACC1_W'(SMP_MIN);
    localparam logic signed [E_W-1:0]    E_MAX  = E_W'(SMP_MAX);
    localparam logic signed [E_W-1:0]    E_MIN  = E_W'(SMP_MIN);
    localparam logic signed [P1_W-1:0]   W_HALF = P1_W'(2 ** (W_SHIFT - 1));
    localparam logic signed [WS_W-1:0]   W_MAX  = WS_W'(WGT_MAX);
    localparam logic signed [WS_W-1:0]   W_MIN  = WS_W'(WGT_MIN);

    // memories
    sample_t                   tmem [TAPS];
    logic signed [WGT_W-1:0]   wmem [TAPS];
    logic [TAPS-1:0]           wval_reg;   // weight entry written since reset or last clear-all

    // control / pointers
    logic [STEP_W-1:0] step_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  rdp_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic              full_reg;
    logic              adapt_reg;
    logic              s1_vld_reg;
    logic              s2_vld_reg;
    logic              out_vld_reg;

    // payload
    sample_t                   desired_reg;
    sample_t                   tap_rd_reg;
    logic signed [WGT_W-1:0]   w_rd_reg;
    logic                      wv_rd_reg;
    logic [IDX_W-1:0]          s1_idx_reg;
    logic [IDX_W-1:0]          s2_idx_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [WGT_W-1:0]   wd_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    sample_t                   y_reg;
    sample_t                   e_reg;
    logic signed [MUE_W-1:0]   mue_reg;
    sample_t                   fout_reg;
    sample_t                   eout_reg;
    logic                      wfull_reg;

    // combinational
    logic [IDX_W-1:0]          head_next;
    logic [IDX_W-1:0]          rdp_next;
    logic [IDX_W-1:0]          idx_next;
    logic                      is_clear;
    logic                      will_full;
    logic signed [WGT_W-1:0]   w_eff;
    logic signed [MUE_W-1:0]   mul_a;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC1_W-1:0]  acc_rnd;
    logic signed [ACC1_W-1:0]  y_wide;
    sample_t                   y_sat;
    logic signed [E_W-1:0]     e_diff;
    sample_t                   e_sat;
    logic signed [MUE_W-2:0]   mu_e;
    logic signed [MUE_W-1:0]   mue_next;
    logic signed [P1_W-1:0]    p_rnd;
    logic signed [WS_W-1:0]    w_sum;
    logic signed [WGT_W-1:0]   w_new;

    assign head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign rdp_next  = (rdp_reg == '0) ? LAST_IDX : rdp_reg - 1'b1;
    assign idx_next  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign is_clear  = (in_action == ACT_CLR_WIN) || (in_action == ACT_CLR_ALL);
    assign will_full = (fill_reg == FULL_CNT) || (fill_reg == FULL_CNT - 1'b1);

    // shared multiplier: weight x tap for the filter pass, 2*mu*e x tap for update
    assign w_eff     = wv_rd_reg ? w_rd_reg : '0;
    assign mul_a     = cmd.upd ? mue_reg : MUE_W'(w_eff);
    assign prod_next = mul_a * tap_rd_reg;

    // y: round half up at bit 20, saturate
    assign acc_rnd = ACC1_W'(acc_reg) + Y_HALF;
    assign y_wide  = acc_rnd >>> Y_SHIFT;
    always_comb
    begin
        if (y_wide > Y_MAX)
        begin
            y_sat = SMP_W'(Y_MAX);
        end
        else if (y_wide < Y_MIN)
        begin
            y_sat = SMP_W'(Y_MIN);
        end
        else
        begin
            y_sat = SMP_W'(y_wide);
        end
    end

    assign e_diff = E_W'(desired_reg) - E_W'(y_sat);
    always_comb
    begin
        if (e_diff > E_MAX)
        begin
            e_sat = SMP_W'(E_MAX);
        end
        else if (e_diff < E_MIN)
        begin
            e_sat = SMP_W'(E_MIN);
        end
        else
        begin
            e_sat = SMP_W'(e_diff);
        end
    end

    assign mu_e     = $signed({1'b0, step_reg}) * e_reg;
    assign mue_next = {mu_e, 1'b0};

    // weight step: round at bit 26, add, saturate to Q4.20
    assign p_rnd = P1_W'(prod_reg) + W_HALF;
    assign w_sum = WS_W'(wd_reg) + WS_W'($signed(p_rnd[P1_W-1:W_SHIFT]));
    always_comb
    begin
        if (w_sum > W_MAX)
        begin
            w_new = WGT_W'(W_MAX);
        end
        else if (w_sum < W_MIN)
        begin
            w_new = WGT_W'(W_MIN);
        end
        else
        begin
            w_new = WGT_W'(w_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= STEP_RESET;
            head_reg    <= '0;
            rdp_reg     <= '0;
            idx_reg     <= '0;
            fill_reg    <= '0;
            full_reg    <= 1'b0;
            adapt_reg   <= 1'b0;
            wval_reg    <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                step_reg <= cfg_wr_data;
            end
            if (cmd.take)
            begin
                if (is_clear)
                begin
                    fill_reg <= '0;
                    if (in_action == ACT_CLR_ALL)
                    begin
                        wval_reg <= '0;
                    end
                end
                else
                begin
                    head_reg  <= head_next;
                    rdp_reg   <= head_next;
                    fill_reg  <= (fill_reg == FULL_CNT) ? fill_reg : fill_reg + 1'b1;
                    full_reg  <= will_full;
                    adapt_reg <= (in_action == ACT_ADAPT);
                end
            end
            if (cmd.issue)
            begin
                idx_reg <= idx_next;
                rdp_reg <= rdp_next;
            end
            if (s2_vld_reg && cmd.upd)
            begin
                wval_reg[s2_idx_reg] <= 1'b1;
            end
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
            if (cmd.load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // memories, registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.take && !is_clear)
        begin
            tmem[head_next] <= in_sample;
        end
        if (cmd.issue)
        begin
            tap_rd_reg <= tmem[rdp_reg];
            w_rd_reg   <= wmem[idx_reg];
        end
        if (s2_vld_reg && cmd.upd)
        begin
            wmem[s2_idx_reg] <= w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            desired_reg <= in_desired;
            acc_reg     <= '0;
            y_reg       <= '0;
            e_reg       <= '0;
        end
        else
        begin
            if (s2_vld_reg && !cmd.upd)
            begin
                acc_reg <= acc_reg + ACC_W'($signed(prod_reg[WP_W-1:0]));
            end
            if (cmd.form_y)
            begin
                y_reg <= y_sat;
                e_reg <= adapt_reg ? e_sat : '0;
            end
        end
        if (cmd.issue)
        begin
            wv_rd_reg  <= wval_reg[idx_reg];
            s1_idx_reg <= idx_reg;
        end
        if (s1_vld_reg)
        begin
            prod_reg   <= prod_next;
            wd_reg     <= w_eff;
            s2_idx_reg <= s1_idx_reg;
        end
        if (cmd.form_mue)
        begin
            mue_reg <= mue_next;
        end
        if (cmd.load_out)
        begin
            fout_reg  <= y_reg;
            eout_reg  <= e_reg;
            wfull_reg <= full_reg;
        end
    end

    assign status.will_full = will_full;
    assign status.last      = (idx_reg == LAST_IDX);
    assign status.drained   = !s1_vld_reg && !s2_vld_reg;
    assign status.adapt     = adapt_reg;
    assign status.out_free  = !out_vld_reg || out_ready;

    assign out_valid   = out_vld_reg;
    assign filter_out  = fout_reg;
    assign error_out   = eout_reg;
    assign window_full = wfull_reg;

    `LMS_ASSERT_IMPL(a_upd_needs_full, clk, rst_n, s2_vld_reg && cmd.upd, full_reg && adapt_reg)
    `LMS_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FULL_CNT)
    `LMS_ASSERT_IMPL(a_take_drained, clk, rst_n, cmd.take, !s1_vld_reg && !s2_vld_reg)
    `LMS_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.load_out, out_vld_reg)

endmodule

`default_nettype wire

// File: rtl/core/lms_adaptive_fir.sv
// Top level of the LMS adaptive FIR core: controller plus datapath.
// Depends on lms_pkg, lms_in_if, lms_out_if, lms_ctrl and lms_dp.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    sample, desired, action
//  out_ch    out  valid / ready    filter_out, error_out, window_full
//  cfg       in   cfg_wr_en        cfg_wr_data -> step_size (mu, Q0.16)
//
// An adapting item with a full window has the single shared multiplier walk
// all taps twice: once for y, once for the weight updates. Filtering walks
// them once, a filling window not at all, and a clear item gives no result.
// Reset clears the window count and the weight valid bits at once; no sweep.
// A result waits in the output register; the next item is taken meanwhile and
// only its hand-over to the output waits for out_ch.ready.
`default_nettype none

module lms_adaptive_fir #(
    parameter int TAPS = lms_pkg::TAPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lms_pkg::STEP_W-1:0]  cfg_wr_data,
    lms_in_if.sink                      in_ch,
    lms_out_if.source                   out_ch
);
    import lms_pkg::*;

    cmd_t    cmd;     // sequencer commands
    status_t status;  // datapath flags back to the sequencer
    logic    in_rdy;

    // item accept: in_ch.valid & in_ch.ready, handled inside the sequencer
    lms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .status    (status),
        .in_ready  (in_rdy),
        .cmd       (cmd)
    );

    assign in_ch.ready = in_rdy;

    // memories, shared multiplier, rounding/saturation and output register
    lms_dp #(
        .TAPS (TAPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_sample   (in_ch.sample),
        .in_desired  (in_ch.desired),
        .in_action   (in_ch.action),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .filter_out  (out_ch.filter_out),
        .error_out   (out_ch.error_out),
        .window_full (out_ch.window_full)
    );

endmodule

`default_nettype wire
